// File: hdl/fvgt_pkg.sv
// ----------------------------------------------------------------------------
// fvgt_pkg
// Shared constants, codes and types of the fair value gap tracker.
// ----------------------------------------------------------------------------
package fvgt_pkg;

  localparam int unsigned MAX_OPEN_GAPS_DEF = 16;
  localparam int unsigned PRICE_BITS_DEF    = 32;

  // bar numbers and output price fields are fixed at 32 bits
  localparam int unsigned BAR_W    = 32;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = $clog2(NUM_REGS) + 2;

  // distance from the first to the third bar of a gap
  localparam int unsigned GAP_SPAN = 2;

  typedef enum logic [KIND_W-1:0] {
    EV_NEW_UP  = 3'd0,
    EV_NEW_DN  = 3'd1,
    EV_FILL_UP = 3'd2,
    EV_FILL_DN = 3'd3,
    EV_NONE    = 3'd4
  } event_kind_e;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_UP_EN   = 3'd0,
    REG_DN_EN   = 3'd1,
    REG_UP_MIN  = 3'd2,
    REG_DN_MIN  = 3'd3,
    REG_UP_EXT  = 3'd4,
    REG_DN_EXT  = 3'd5,
    REG_UP_HIDE = 3'd6,
    REG_DN_HIDE = 3'd7
  } reg_idx_e;

  // token walking down the cell row, one cell per cycle while the result side is not stalled
  typedef struct packed {
    logic active;
    logic up_pend;     // new up gap still looking for a free slot
    logic dn_pend;     // new down gap still looking for a free slot
    logic all_filled;  // every cell so far held a gap that this bar filled
  } tok_t;

  typedef struct packed {
    logic up_extend;
    logic dn_extend;
    logic up_hide;
    logic dn_hide;
  } fill_cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] far_price;
    logic [FIELD_W-1:0] near_price;
    logic [BAR_W-1:0]   end_bar;
    logic [BAR_W-1:0]   begin_bar;
    logic               tracked;
    logic               hidden;
    logic [KIND_W-1:0]  kind;
  } res_t;

endpackage

// File: hdl/fvgt_cell.sv
// ----------------------------------------------------------------------------
// fvgt_cell
// One slot of the open gap table. Checks the bar for a fill while the token
// sits here, takes a pending new gap when free, and hands the token on.
// ----------------------------------------------------------------------------
module fvgt_cell #(
  parameter int unsigned PRICE_BITS = fvgt_pkg::PRICE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        start_i,
  input  logic                        cancel_i,
  input  fvgt_pkg::tok_t              tok_i,
  output fvgt_pkg::tok_t              tok_o,
  input  fvgt_pkg::fill_cfg_t         cfg_i,
  input  logic [PRICE_BITS-1:0]       bar_high_i,
  input  logic [PRICE_BITS-1:0]       bar_low_i,
  input  logic [fvgt_pkg::BAR_W-1:0]  now_i,
  input  logic [fvgt_pkg::BAR_W-1:0]  new_begin_i,
  input  logic [PRICE_BITS-1:0]       up_near_i,
  input  logic [PRICE_BITS-1:0]       dn_near_i,
  output logic                        emit_o,
  output fvgt_pkg::res_t              res_o
);

  fvgt_pkg::tok_t tok_q;
  logic valid_q, valid_d;
  logic new_dn_q, new_dn_d;

  logic                       up_q;
  logic [fvgt_pkg::BAR_W-1:0] begin_q;
  logic [PRICE_BITS-1:0]      near_q;
  logic [PRICE_BITS-1:0]      far_q;

  logic act, fill, free, store_up, store_dn;

  assign act  = tok_q.active;
  assign fill = valid_q && (up_q ? (bar_low_i <= near_q) : (bar_high_i >= near_q));
  assign free = !valid_q || fill;
  assign store_up = act && free && tok_q.up_pend;
  assign store_dn = act && free && !tok_q.up_pend && tok_q.dn_pend;
  assign emit_o   = act && fill;

  always_comb begin
    tok_o = '0;
    if (act) begin
      tok_o.active     = 1'b1;
      tok_o.up_pend    = tok_q.up_pend && !store_up;
      tok_o.dn_pend    = tok_q.dn_pend && !store_dn;
      tok_o.all_filled = tok_q.all_filled && fill;
    end
  end

  always_comb begin
    res_o = '0;
    if (emit_o) begin
      res_o.kind       = up_q ? fvgt_pkg::EV_FILL_UP : fvgt_pkg::EV_FILL_DN;
      res_o.begin_bar  = begin_q;
      res_o.end_bar    = (up_q ? cfg_i.up_extend : cfg_i.dn_extend) ? now_i
                         : begin_q + fvgt_pkg::BAR_W'(fvgt_pkg::GAP_SPAN);
      res_o.near_price = fvgt_pkg::FIELD_W'(near_q);
      res_o.far_price  = fvgt_pkg::FIELD_W'(far_q);
      res_o.hidden     = up_q ? cfg_i.up_hide : cfg_i.dn_hide;
      res_o.tracked    = 1'b0;
    end
  end

  always_comb begin
    valid_d  = valid_q;
    new_dn_d = new_dn_q;
    if (en_i) begin
      if (start_i) begin
        new_dn_d = 1'b0;
      end
      if (store_up || store_dn) begin
        valid_d = 1'b1;
      end else if (emit_o) begin
        valid_d = 1'b0;
      end
      if (store_dn) begin
        new_dn_d = 1'b1;
      end
    end
    // a down gap past the result cap is taken back out
    if (cancel_i && new_dn_q) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      valid_q  <= 1'b0;
      new_dn_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      new_dn_q <= new_dn_d;
      if (en_i) begin
        tok_q <= tok_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store_up) begin
      up_q    <= 1'b1;
      begin_q <= new_begin_i;
      near_q  <= up_near_i;
      far_q   <= bar_low_i;
    end else if (en_i && store_dn) begin
      up_q    <= 1'b0;
      begin_q <= new_begin_i;
      near_q  <= dn_near_i;
      far_q   <= bar_high_i;
    end
  end

endmodule

// File: hdl/fair_value_gap_tracker.sv
// ----------------------------------------------------------------------------
// fair_value_gap_tracker
// Three-bar fair value gap detector with a table of open gaps.
// ----------------------------------------------------------------------------
// Each bar item is handled in steps: the bar is taken, then a token walks the
// row of slot cells (fills are reported in slot order as it passes), then the
// new up gap, the new down gap and the closing result that carries tlast are
// handled in turn. Output stalls hold every step after the bar is taken. The
// next bar is taken once the closing result is in the output register.
// ----------------------------------------------------------------------------
module fair_value_gap_tracker #(
  parameter int unsigned MAX_OPEN_GAPS = fvgt_pkg::MAX_OPEN_GAPS_DEF,
  parameter int unsigned PRICE_BITS    = fvgt_pkg::PRICE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // bar items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // bar_high, bar_low
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [127:0]                m_axis_tdata,   // begin_bar, end_bar,
                                                      // near_price, far_price
  output logic [4:0]                  m_axis_tuser,   // event_kind, hidden, tracked
  output logic                        m_axis_tlast,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fvgt_pkg::ADDR_W-1:0] paddr,
  input  logic [fvgt_pkg::REG_W-1:0]  pwdata,
  output logic [fvgt_pkg::REG_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned DW = (PRICE_BITS > fvgt_pkg::REG_W) ? PRICE_BITS
                                                              : fvgt_pkg::REG_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_UP    = 5'b00100,
    S_DN    = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  // ---------------- configuration ----------------
  logic                       up_en_q, dn_en_q;
  logic [fvgt_pkg::REG_W-1:0] up_min_q, dn_min_q;
  fvgt_pkg::fill_cfg_t        cfg_q;
  logic                       cfg_wr;
  fvgt_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = fvgt_pkg::reg_idx_e'(paddr[fvgt_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_en_q  <= 1'b1;
      dn_en_q  <= 1'b1;
      up_min_q <= fvgt_pkg::REG_W'(1);
      dn_min_q <= fvgt_pkg::REG_W'(1);
      cfg_q    <= '1;
    end else if (cfg_wr) begin
      case (reg_idx)
        fvgt_pkg::REG_UP_EN:   up_en_q         <= pwdata[0];
        fvgt_pkg::REG_DN_EN:   dn_en_q         <= pwdata[0];
        fvgt_pkg::REG_UP_MIN:  up_min_q        <= pwdata;
        fvgt_pkg::REG_DN_MIN:  dn_min_q        <= pwdata;
        fvgt_pkg::REG_UP_EXT:  cfg_q.up_extend <= pwdata[0];
        fvgt_pkg::REG_DN_EXT:  cfg_q.dn_extend <= pwdata[0];
        fvgt_pkg::REG_UP_HIDE: cfg_q.up_hide   <= pwdata[0];
        fvgt_pkg::REG_DN_HIDE: cfg_q.dn_hide   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      fvgt_pkg::REG_UP_EN:   prdata[0] = up_en_q;
      fvgt_pkg::REG_DN_EN:   prdata[0] = dn_en_q;
      fvgt_pkg::REG_UP_MIN:  prdata    = up_min_q;
      fvgt_pkg::REG_DN_MIN:  prdata    = dn_min_q;
      fvgt_pkg::REG_UP_EXT:  prdata[0] = cfg_q.up_extend;
      fvgt_pkg::REG_DN_EXT:  prdata[0] = cfg_q.dn_extend;
      fvgt_pkg::REG_UP_HIDE: prdata[0] = cfg_q.up_hide;
      fvgt_pkg::REG_DN_HIDE: prdata[0] = cfg_q.dn_hide;
      default:               prdata    = '0;
    endcase
  end

  // ---------------- bar history and detection ----------------
  state_e state_q, state_d;

  logic [PRICE_BITS-1:0]      prev_high_q [2];
  logic [PRICE_BITS-1:0]      prev_low_q  [2];
  logic [fvgt_pkg::BAR_W-1:0] bar_cnt_q;
  logic [PRICE_BITS-1:0]      bar_hi_q, bar_lo_q;
  logic [fvgt_pkg::BAR_W-1:0] begin_q;
  logic                       up_new_q, dn_new_q;
  logic                       up_trk_q, dn_trk_q, drop_q;

  logic [PRICE_BITS-1:0] in_hi, in_lo, h3, l3, up_diff, dn_diff;
  logic                  accept, up_new_d, dn_new_d, det_ok;

  assign in_hi = PRICE_BITS'(s_axis_tdata[31:0]);
  assign in_lo = PRICE_BITS'(s_axis_tdata[63:32]);
  assign h3    = prev_high_q[1];
  assign l3    = prev_low_q[1];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign det_ok   = bar_cnt_q >= fvgt_pkg::BAR_W'(fvgt_pkg::GAP_SPAN);
  assign up_diff  = in_lo - h3;
  assign dn_diff  = l3 - in_hi;
  assign up_new_d = det_ok && up_en_q && (h3 < in_lo) && (DW'(up_diff) >= DW'(up_min_q));
  assign dn_new_d = det_ok && dn_en_q && (l3 > in_hi) && (DW'(dn_diff) >= DW'(dn_min_q));

  // ---------------- cell row ----------------
  fvgt_pkg::tok_t tok_w [MAX_OPEN_GAPS+1];
  logic           emit_w [MAX_OPEN_GAPS];
  fvgt_pkg::res_t res_w  [MAX_OPEN_GAPS];
  logic           chain_en, start, cancel;
  fvgt_pkg::tok_t start_tok;

  always_comb begin
    start_tok            = '0;
    start_tok.active     = 1'b1;
    start_tok.up_pend    = up_new_d;
    start_tok.dn_pend    = dn_new_d;
    start_tok.all_filled = 1'b1;
  end

  assign tok_w[0] = start ? start_tok : '0;

  for (genvar g = 0; g < MAX_OPEN_GAPS; g++) begin : g_cell
    fvgt_cell #(
      .PRICE_BITS (PRICE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (chain_en),
      .start_i     (start),
      .cancel_i    (cancel),
      .tok_i       (tok_w[g]),
      .tok_o       (tok_w[g+1]),
      .cfg_i       (cfg_q),
      .bar_high_i  (bar_hi_q),
      .bar_low_i   (bar_lo_q),
      .now_i       (bar_cnt_q),
      .new_begin_i (begin_q),
      .up_near_i   (h3),
      .dn_near_i   (l3),
      .emit_o      (emit_w[g]),
      .res_o       (res_w[g])
    );
  end

  // only the cell holding the token can report, so an OR picks its result
  logic           cell_emit;
  fvgt_pkg::res_t cell_res;

  always_comb begin
    cell_emit = 1'b0;
    cell_res  = '0;
    for (int i = 0; i < MAX_OPEN_GAPS; i++) begin
      cell_emit = cell_emit | emit_w[i];
      cell_res  = cell_res | res_w[i];
    end
  end

  fvgt_pkg::tok_t tail;
  assign tail = tok_w[MAX_OPEN_GAPS];

  // ---------------- new gap results ----------------
  fvgt_pkg::res_t up_res, dn_res;

  always_comb begin
    up_res            = '0;
    up_res.kind       = fvgt_pkg::EV_NEW_UP;
    up_res.begin_bar  = begin_q;
    up_res.end_bar    = bar_cnt_q;
    up_res.near_price = fvgt_pkg::FIELD_W'(h3);
    up_res.far_price  = fvgt_pkg::FIELD_W'(bar_lo_q);
    up_res.tracked    = up_trk_q;
    dn_res            = '0;
    dn_res.kind       = fvgt_pkg::EV_NEW_DN;
    dn_res.begin_bar  = begin_q;
    dn_res.end_bar    = bar_cnt_q;
    dn_res.near_price = fvgt_pkg::FIELD_W'(l3);
    dn_res.far_price  = fvgt_pkg::FIELD_W'(bar_hi_q);
    dn_res.tracked    = dn_trk_q;
  end

  // ---------------- sequencer ----------------
  // results go through a one-deep hold so the final one can carry tlast
  fvgt_pkg::res_t out_q, pend_q, push_res, quiet_res;
  logic           out_valid_q, out_last_q, pend_valid_q;
  logic           out_free, push, flush, tail_hit;

  assign out_free = !out_valid_q || m_axis_tready;
  assign tail_hit = (state_q == S_SCAN) && out_free && tail.active;

  always_comb begin
    quiet_res      = '0;
    quiet_res.kind = fvgt_pkg::EV_NONE;
  end

  always_comb begin
    state_d  = state_q;
    chain_en = 1'b0;
    start    = 1'b0;
    cancel   = 1'b0;
    push     = 1'b0;
    push_res = '0;
    flush    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          chain_en = 1'b1;
          start    = 1'b1;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          chain_en = 1'b1;
          push     = cell_emit;
          push_res = cell_res;
          if (tail.active) begin
            state_d = S_UP;
          end
        end
      end
      S_UP: begin
        cancel = drop_q;
        if (out_free) begin
          push     = up_new_q;
          push_res = up_res;
          state_d  = S_DN;
        end
      end
      S_DN: begin
        if (out_free) begin
          push     = dn_new_q && !drop_q;
          push_res = dn_res;
          state_d  = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      prev_high_q[0] <= '0;
      prev_high_q[1] <= '0;
      prev_low_q[0]  <= '0;
      prev_low_q[1]  <= '0;
      bar_cnt_q      <= '0;
      up_new_q       <= 1'b0;
      dn_new_q       <= 1'b0;
      up_trk_q       <= 1'b0;
      dn_trk_q       <= 1'b0;
      drop_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      out_last_q     <= 1'b0;
      pend_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        up_new_q <= up_new_d;
        dn_new_q <= dn_new_d;
      end
      if (tail_hit) begin
        up_trk_q <= !tail.up_pend;
        dn_trk_q <= !tail.dn_pend;
        // every slot filled plus a new up gap already reaches the result cap
        drop_q   <= tail.all_filled && up_new_q && dn_new_q;
      end
      if (flush) begin
        prev_high_q[1] <= prev_high_q[0];
        prev_low_q[1]  <= prev_low_q[0];
        prev_high_q[0] <= bar_hi_q;
        prev_low_q[0]  <= bar_lo_q;
        bar_cnt_q      <= bar_cnt_q + fvgt_pkg::BAR_W'(1);
      end

      if (push && pend_valid_q) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b0;
      end else if (flush) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (push) begin
        pend_valid_q <= 1'b1;
      end else if (flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bar_hi_q <= in_hi;
      bar_lo_q <= in_lo;
      begin_q  <= bar_cnt_q - fvgt_pkg::BAR_W'(fvgt_pkg::GAP_SPAN);
    end
    if (push && pend_valid_q) begin
      out_q <= pend_q;
    end else if (flush) begin
      out_q <= pend_valid_q ? pend_q : quiet_res;
    end
    if (push) begin
      pend_q <= push_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_q.far_price, out_q.near_price, out_q.end_bar, out_q.begin_bar};
  assign m_axis_tuser  = {out_q.tracked, out_q.hidden, out_q.kind};

endmodule
